### design/cpa_pkg.sv
// Shared types and constants for the contiguous page allocator.
package cpa_pkg;

    localparam int TOTAL_PAGES    = 1024;
    localparam int RESERVED_PAGES = 1;

    // Reservation is clipped to the heap size.
    localparam int RES_EFF = (RESERVED_PAGES < TOTAL_PAGES) ? RESERVED_PAGES : TOTAL_PAGES;

    localparam int ADDR_W = $clog2(TOTAL_PAGES);
    localparam int CNT_W  = $clog2(TOTAL_PAGES + 1);

    // Field widths of the request and response words.
    localparam int COUNT_W  = 11;
    localparam int INDEX_W  = 10;
    localparam int STATUS_W = 3;
    localparam int START_W  = 10;
    localparam int TOTAL_W  = 11;

    localparam int CMP_W = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;

    typedef logic [ADDR_W-1:0] t_addr;
    typedef logic [ADDR_W:0]   t_scan;
    typedef logic [CNT_W-1:0]  t_cnt;

    localparam t_addr ADDR_LAST  = t_addr'(TOTAL_PAGES - 1);
    localparam t_addr RES_LAST   = t_addr'(RES_EFF - 1);
    localparam t_scan SCAN_END   = t_scan'(TOTAL_PAGES);
    localparam t_scan RES_BOUND  = t_scan'(RES_EFF);
    localparam t_cnt  CNT_TOTAL  = t_cnt'(TOTAL_PAGES);
    localparam t_cnt  FREE_RESET = t_cnt'(TOTAL_PAGES - RES_EFF);

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK         = 3'd0,
        ST_ZERO_COUNT = 3'd1,
        ST_NO_SPACE   = 3'd2,
        ST_NOT_TAKEN  = 3'd3,
        ST_RANGE      = 3'd4
    } t_status;

    typedef struct packed {
        logic taken;
        logic last;
    } t_page;

    typedef struct packed {
        logic  en;
        t_addr addr;
        t_page data;
    } t_wr;

endpackage

### design/cpa_if.sv
// Request and response channel interfaces of the page allocator.
interface cpa_req_if;
    logic                         valid;
    logic                         ready;
    logic                         command;
    logic [cpa_pkg::COUNT_W-1:0]  page_count;
    logic [cpa_pkg::INDEX_W-1:0]  page_index;

    modport source (output valid, command, page_count, page_index, input ready);
    modport sink   (input valid, command, page_count, page_index, output ready);
endinterface

interface cpa_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [cpa_pkg::STATUS_W-1:0]  status;
    logic [cpa_pkg::START_W-1:0]   start_index;
    logic [cpa_pkg::TOTAL_W-1:0]   free_pages;
    logic [cpa_pkg::TOTAL_W-1:0]   taken_pages;

    modport source (output valid, status, start_index, free_pages, taken_pages, input ready);
    modport sink   (input valid, status, start_index, free_pages, taken_pages, output ready);
endinterface

### design/cpa_bitmap.sv
// Page bitmap memory: taken and last bits, one write and one registered read port.
module cpa_bitmap (
    input  logic                i_clk,
    input  cpa_pkg::t_wr        i_wr,
    input  logic                i_rd_en,
    input  cpa_pkg::t_addr      i_rd_addr,
    output cpa_pkg::t_page      o_rd_data
);

    cpa_pkg::t_page r_mem [cpa_pkg::TOTAL_PAGES];
    cpa_pkg::t_page r_q;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        if (i_rd_en) begin
            r_q <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_q;

endmodule

### design/contiguous_page_allocator.sv
// First-fit contiguous page allocator over a taken/last page bitmap.
//
//   port    dir  word                                                  handshake
//   i_req   in   command, page_count, page_index                      valid/ready
//   o_rsp   out  status, start_index, free_pages, taken_pages         valid/ready
//
// Allocate: scan of one bitmap entry per cycle through the memory read port,
//   then one write per page of the run, then a load into the output register.
// Free: walk of one page per cycle to the next last mark, untaken page or top page.
// Zero count or bad index: the error status goes straight to the output load.
// After reset a clearing pass writes every entry before ready.
// A stalled response holds in the output register; the next word is still accepted.
module contiguous_page_allocator (
    input  logic            i_clk,
    input  logic            i_rst_n,
    cpa_req_if.sink         i_req,
    cpa_rsp_if.source       o_rsp
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_FILL,
        S_WALK,
        S_DONE
    } t_state;

    t_state                         r_state, n_state;
    cpa_pkg::t_addr                 r_wa, n_wa;
    cpa_pkg::t_addr                 r_end, n_end;
    cpa_pkg::t_addr                 r_start, n_start;
    cpa_pkg::t_scan                 r_ra, n_ra;
    cpa_pkg::t_addr                 r_pa, n_pa;
    logic                           r_pv, n_pv;
    logic                           r_first, n_first;
    cpa_pkg::t_cnt                  r_run, n_run;
    logic [cpa_pkg::COUNT_W-1:0]    r_count, n_count;
    cpa_pkg::t_cnt                  r_free, n_free;
    cpa_pkg::t_status               r_status, n_status;

    logic                           r_o_valid, n_o_valid;
    logic [cpa_pkg::STATUS_W-1:0]   r_o_status, n_o_status;
    logic [cpa_pkg::START_W-1:0]    r_o_start, n_o_start;
    logic [cpa_pkg::TOTAL_W-1:0]    r_o_free, n_o_free;
    logic [cpa_pkg::TOTAL_W-1:0]    r_o_taken, n_o_taken;

    cpa_pkg::t_wr                   wr;
    logic                           rd_en;
    cpa_pkg::t_page                 rd_q;
    cpa_pkg::t_cnt                  run_inc;
    logic                           issue;

    cpa_bitmap u_bitmap (
        .i_clk     (i_clk),
        .i_wr      (wr),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_ra[cpa_pkg::ADDR_W-1:0]),
        .o_rd_data (rd_q)
    );

    assign i_req.ready       = (r_state == S_IDLE);
    assign o_rsp.valid       = r_o_valid;
    assign o_rsp.status      = r_o_status;
    assign o_rsp.start_index = r_o_start;
    assign o_rsp.free_pages  = r_o_free;
    assign o_rsp.taken_pages = r_o_taken;

    assign run_inc = r_run + 1'b1;
    assign issue   = (r_state == S_SCAN || r_state == S_WALK) && (r_ra < cpa_pkg::SCAN_END);

    always_comb begin
        n_state    = r_state;
        n_wa       = r_wa;
        n_end      = r_end;
        n_start    = r_start;
        n_ra       = r_ra;
        n_pa       = r_pa;
        n_pv       = r_pv;
        n_first    = r_first;
        n_run      = r_run;
        n_count    = r_count;
        n_free     = r_free;
        n_status   = r_status;
        n_o_valid  = r_o_valid && !o_rsp.ready;
        n_o_status = r_o_status;
        n_o_start  = r_o_start;
        n_o_free   = r_o_free;
        n_o_taken  = r_o_taken;
        wr         = '0;
        rd_en      = 1'b0;

        // Read-ahead: one entry issued per cycle, data examined the next cycle.
        if (issue) begin
            rd_en = 1'b1;
            n_ra  = r_ra + 1'b1;
            n_pa  = r_ra[cpa_pkg::ADDR_W-1:0];
        end
        n_pv = issue;

        case (r_state)
            S_CLEAR: begin
                wr.en         = 1'b1;
                wr.addr       = r_wa;
                wr.data.taken = ({1'b0, r_wa} < cpa_pkg::RES_BOUND);
                wr.data.last  = (r_wa == cpa_pkg::RES_LAST);
                n_wa          = r_wa + 1'b1;
                if (r_wa == cpa_pkg::ADDR_LAST) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                n_pv    = 1'b0;
                n_start = '0;
                if (i_req.valid) begin
                    if (i_req.command == cpa_pkg::CMD_ALLOC) begin
                        n_count = i_req.page_count;
                        n_run   = '0;
                        n_ra    = '0;
                        if (i_req.page_count == '0) begin
                            n_status = cpa_pkg::ST_ZERO_COUNT;
                            n_state  = S_DONE;
                        end else begin
                            n_state = S_SCAN;
                        end
                    end else begin
                        n_first = 1'b1;
                        n_ra    = cpa_pkg::t_scan'(i_req.page_index);
                        if (32'(i_req.page_index) >= 32'(cpa_pkg::TOTAL_PAGES)) begin
                            n_status = cpa_pkg::ST_RANGE;
                            n_state  = S_DONE;
                        end else begin
                            n_state = S_WALK;
                        end
                    end
                end
            end
            S_SCAN: begin
                if (r_pv) begin
                    if (!rd_q.taken && !rd_q.last) begin
                        n_run = run_inc;
                        if (r_run == '0) begin
                            n_start = r_pa;
                        end
                        if (cpa_pkg::CMP_W'(run_inc) >= cpa_pkg::CMP_W'(r_count)) begin
                            n_wa    = (r_run == '0) ? r_pa : r_start;
                            n_end   = r_pa;
                            n_state = S_FILL;
                        end else if (r_pa == cpa_pkg::ADDR_LAST) begin
                            n_start  = '0;
                            n_status = cpa_pkg::ST_NO_SPACE;
                            n_state  = S_DONE;
                        end
                    end else begin
                        n_run = '0;
                        if (r_pa == cpa_pkg::ADDR_LAST) begin
                            n_start  = '0;
                            n_status = cpa_pkg::ST_NO_SPACE;
                            n_state  = S_DONE;
                        end
                    end
                end
            end
            S_FILL: begin
                wr.en         = 1'b1;
                wr.addr       = r_wa;
                wr.data.taken = 1'b1;
                wr.data.last  = (r_wa == r_end);
                n_wa          = r_wa + 1'b1;
                n_free        = r_free - 1'b1;
                if (r_wa == r_end) begin
                    n_status = cpa_pkg::ST_OK;
                    n_state  = S_DONE;
                end
            end
            S_WALK: begin
                if (r_pv) begin
                    n_first = 1'b0;
                    if (r_first && !rd_q.taken) begin
                        n_status = cpa_pkg::ST_NOT_TAKEN;
                        n_state  = S_DONE;
                    end else begin
                        // Every visited page ends with both bits clear.
                        wr.en   = 1'b1;
                        wr.addr = r_pa;
                        wr.data = '0;
                        if (rd_q.taken) begin
                            n_free = r_free + 1'b1;
                        end
                        if (!rd_q.taken || rd_q.last || r_pa == cpa_pkg::ADDR_LAST) begin
                            n_status = cpa_pkg::ST_OK;
                            n_state  = S_DONE;
                        end
                    end
                end
            end
            S_DONE: begin
                if (!r_o_valid || o_rsp.ready) begin
                    n_o_valid  = 1'b1;
                    n_o_status = r_status;
                    n_o_start  = cpa_pkg::START_W'(r_start);
                    n_o_free   = cpa_pkg::TOTAL_W'(r_free);
                    n_o_taken  = cpa_pkg::TOTAL_W'(cpa_pkg::CNT_TOTAL - r_free);
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_wa      <= '0;
            r_pv      <= 1'b0;
            r_free    <= cpa_pkg::FREE_RESET;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_wa      <= n_wa;
            r_pv      <= n_pv;
            r_free    <= n_free;
            r_o_valid <= n_o_valid;
        end
        r_end      <= n_end;
        r_start    <= n_start;
        r_ra       <= n_ra;
        r_pa       <= n_pa;
        r_first    <= n_first;
        r_run      <= n_run;
        r_count    <= n_count;
        r_status   <= n_status;
        r_o_status <= n_o_status;
        r_o_start  <= n_o_start;
        r_o_free   <= n_o_free;
        r_o_taken  <= n_o_taken;
    end

endmodule
